[sv/strided_decode_attempt_scheduler_macros.svh]
// assertion helpers shared by the scheduler modules
// each expects clk_i and rst_ni in the scope where it is used
`ifndef STRIDED_DECODE_ATTEMPT_SCHEDULER_MACROS_SVH
`define STRIDED_DECODE_ATTEMPT_SCHEDULER_MACROS_SVH

// same-cycle implication
`define SDAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sdas_pkg.sv]
// ----------------------------------------------------------------------------
// sdas_pkg
// types and constants shared by the decode attempt scheduler modules
// ----------------------------------------------------------------------------
package sdas_pkg;

  localparam int unsigned CNT_W         = 16;
  localparam int unsigned TOT_W         = 18;
  localparam int unsigned SP_W          = 3;
  localparam int unsigned REP_W         = 8;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned CFG_IDX_W     = 2;

  // request codes
  localparam logic [1:0] OP_NEXT   = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SYMBOLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBPASS_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPETITIONS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_MASK   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] packet_index;
    logic [CNT_W-1:0] symbol_count;
    logic             finished;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] next_symbols;
  } out_item_t;

  // one packet slot of the store
  typedef struct packed {
    logic [SP_W-1:0]  position;
    logic [CNT_W-1:0] proposed;
    logic [CNT_W-1:0] tried;
  } slot_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic clr_en;
    logic acc_load;
    logic acc_step;
    logic wr_en;
    logic res_zero;
    logic res_total;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       slot_ok;
    logic       give_up;
    logic       passed;
    logic       clr_done;
    logic       out_free;
  } dp_status_t;

endpackage

[sv/sdas_stream_if.sv]
// ----------------------------------------------------------------------------
// sdas_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface sdas_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/sdas_datapath.sv]
// ----------------------------------------------------------------------------
// sdas_datapath
// config registers, slot store, running-total accumulator and result register
// ----------------------------------------------------------------------------
module sdas_datapath #(
  parameter int unsigned NUM_PACKETS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdas_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  sdas_pkg::in_item_t                 in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output sdas_pkg::out_item_t                out_data_o,
  input  sdas_pkg::ctrl_cmd_t                cmd_i,
  output sdas_pkg::dp_status_t               status_o
);

  localparam int unsigned AW = (NUM_PACKETS > 1) ? $clog2(NUM_PACKETS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PACKETS - 1);

  // config
  logic [sdas_pkg::CNT_W-1:0] max_q, base_q;
  logic [sdas_pkg::REP_W-1:0] rep_q, mask_q;

  // request and slot read
  sdas_pkg::in_item_t req_q;
  sdas_pkg::slot_t    rd_q;
  sdas_pkg::slot_t    mem_q [NUM_PACKETS];

  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] rd_addr, wr_addr;
  sdas_pkg::slot_t wr_data;
  logic          mem_we;

  // accumulator
  logic [sdas_pkg::TOT_W-1:0] total_q, total_d;
  logic [sdas_pkg::SP_W-1:0]  sp_q, sp_d;
  logic [sdas_pkg::TOT_W-1:0] sub_sym;
  logic [sdas_pkg::CNT_W-1:0] clipped;

  logic [sdas_pkg::CNT_W-1:0] res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  logic [sdas_pkg::CNT_W-1:0] out_data_q;
  logic                       all_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '1;
      base_q <= sdas_pkg::CNT_W'(1);
      rep_q  <= sdas_pkg::REP_W'(1);
      mask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdas_pkg::CFG_MAX_SYMBOLS:  max_q  <= cfg_wdata_i;
        sdas_pkg::CFG_SUBPASS_BASE: base_q <= cfg_wdata_i;
        sdas_pkg::CFG_REPETITIONS:  rep_q  <= cfg_wdata_i[sdas_pkg::REP_W-1:0];
        sdas_pkg::CFG_EXTRA_MASK:   mask_q <= cfg_wdata_i[sdas_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  // slot store, single write port and one registered read port
  assign rd_addr = AW'(in_data_i.packet_index);
  assign mem_we  = cmd_i.clr_en | cmd_i.wr_en;
  assign wr_addr = cmd_i.clr_en ? clr_addr_q : AW'(req_q.packet_index);

  always_comb begin
    wr_data = '0;
    if (!cmd_i.clr_en) begin
      case (req_q.op)
        sdas_pkg::OP_NEXT: begin
          wr_data.position = sp_q;
          wr_data.proposed = clipped;
          wr_data.tried    = rd_q.tried;
        end
        sdas_pkg::OP_RECORD: begin
          wr_data.position = rd_q.position;
          wr_data.proposed = rd_q.proposed;
          wr_data.tried    = req_q.finished ? max_q : req_q.symbol_count;
        end
        default: wr_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.accept) begin
      rd_q  <= mem_q[rd_addr];
      req_q <= in_data_i;
    end
  end

  assign clr_addr_d = cmd_i.clr_en ? clr_addr_q + AW'(1) : clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
    end
  end

  // one subpass per step
  assign sub_sym = sdas_pkg::TOT_W'(base_q)
                 + (mask_q[sp_q] ? sdas_pkg::TOT_W'(rep_q) : '0);
  assign clipped = (total_q > sdas_pkg::TOT_W'(max_q)) ? max_q
                                                       : total_q[sdas_pkg::CNT_W-1:0];

  always_comb begin
    total_d = total_q;
    sp_d    = sp_q;
    if (cmd_i.acc_load) begin
      total_d = sdas_pkg::TOT_W'(rd_q.proposed);
      sp_d    = rd_q.position;
    end else if (cmd_i.acc_step) begin
      total_d = total_q + sub_sym;
      sp_d    = sp_q + sdas_pkg::SP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    sp_q    <= sp_d;
    res_q   <= res_d;
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.res_zero) begin
      res_d = '0;
    end else if (cmd_i.res_total) begin
      res_d = clipped;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.next_symbols = out_data_q;

  assign all_zero = (base_q == '0) && ((rep_q == '0) || (mask_q == '0));

  assign status_o.op       = req_q.op;
  assign status_o.slot_ok  = 32'(req_q.packet_index) < NUM_PACKETS;
  assign status_o.give_up  = (rd_q.tried >= max_q) || all_zero;
  assign status_o.passed   = total_q > sdas_pkg::TOT_W'(rd_q.tried);
  assign status_o.clr_done = clr_addr_q == LAST_ADDR;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

[sv/sdas_ctrl.sv]
// ----------------------------------------------------------------------------
// sdas_ctrl
// sequencer: clearing pass, slot lookup, accumulate loop, result hand-off
// ----------------------------------------------------------------------------
`include "strided_decode_attempt_scheduler_macros.svh"

module sdas_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  sdas_pkg::dp_status_t status_i,
  output sdas_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_IDLE;
        case (status_i.op)
          sdas_pkg::OP_NEXT: begin
            if (!status_i.slot_ok || status_i.give_up) begin
              cmd_o.res_zero = 1'b1;
              state_d        = S_OUT;
            end else begin
              cmd_o.acc_load = 1'b1;
              state_d        = S_ACC;
            end
          end
          sdas_pkg::OP_RECORD, sdas_pkg::OP_CLEAR: begin
            cmd_o.wr_en = status_i.slot_ok;
          end
          default: ;
        endcase
      end
      S_ACC: begin
        if (status_i.passed) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.res_total = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.acc_step = 1'b1;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `SDAS_ASSERT_NEXT(a_accept_then_lookup, cmd_o.accept, state_q == S_LOOK, "accept not followed by lookup")
  `SDAS_ASSERT_NOW(a_load_into_free_slot, cmd_o.out_load, status_i.out_free, "result register overwritten")
  `SDAS_ASSERT_NOW(a_clear_exclusive, cmd_o.clr_en, !cmd_o.wr_en && !cmd_o.in_ready, "clearing pass overlaps a request")

endmodule

[sv/strided_decode_attempt_scheduler.sv]
// sequence: a record or slot reset request to an in-range slot is written in the lookup state after
// its accept beat; a next-count request adds its subpasses one per cycle through the single
// accumulator adder, then waits for a free result register; a give-up result skips the adder
// throughput: one request at a time, next beat taken the cycle after the request completes
// reset: config to defaults, then a clearing pass over every slot of the store with ready held low
// ----------------------------------------------------------------------------
// strided_decode_attempt_scheduler
// proposes symbol counts for successive decode attempts of each packet slot
// ----------------------------------------------------------------------------
module strided_decode_attempt_scheduler #(
  parameter int unsigned NUM_PACKETS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [sdas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdas_pkg::CNT_W-1:0]      cfg_wdata_i,
  // request and result channels
  sdas_stream_if.sink                     req_i,
  sdas_stream_if.source                   rsp_o
);

  // command and status between sequencer and datapath
  sdas_pkg::ctrl_cmd_t  cmd;
  sdas_pkg::dp_status_t status;

  sdas_pkg::in_item_t  req_data;
  sdas_pkg::out_item_t rsp_data;
  logic                rsp_valid;

  // request beat is taken only in the idle state; the result register lets
  // record and slot reset requests pass a held result, while a following
  // next-count request waits at its hand-off until the register frees up
  assign req_i.ready = cmd.in_ready;
  assign req_data    = req_i.data;

  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

  sdas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // slot store, config and accumulator; the store is swept to zero after reset
  sdas_datapath #(
    .NUM_PACKETS (NUM_PACKETS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (req_data),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_valid),
    .out_data_o  (rsp_data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the decode attempt scheduler beat by beat against a model of the
// per-slot subpass walk, over several register settings and random traffic
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned ADD_CAP       = 300;       // longest subpass walk allowed
  localparam int unsigned SETTLE_CYCLES = 8;         // lets the last record/clear land
  localparam int unsigned HOLD_CYCLES   = 400;       // long result back-pressure
  localparam int unsigned HOLD_AFTER    = 150;       // results seen before that hold
  localparam int unsigned TAIL_ITEMS    = 150;       // no idling at the very end
  localparam int unsigned NUM_PHASES    = 8;
  localparam longint      LIMIT_TIME    = 50_000_000;

  // unused request code, must be ignored by the block
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  typedef struct {
    logic [sdas_pkg::CNT_W-1:0] max_sym;
    logic [sdas_pkg::CNT_W-1:0] base;
    logic [sdas_pkg::REP_W-1:0] reps;
    logic [7:0]                 mask;
    int unsigned                items;
  } phase_t;

  // --------------------------------------------------------------------------
  // model of the scheduler plus the queue of counts still to come back
  // --------------------------------------------------------------------------
  class attempt_model;
    int unsigned                max_symbols;
    int unsigned                subpass_base;
    int unsigned                repetitions;
    logic [7:0]                 extra_mask;
    logic [sdas_pkg::SP_W-1:0]  position [SLOTS];
    logic [sdas_pkg::CNT_W-1:0] proposed [SLOTS];
    logic [sdas_pkg::CNT_W-1:0] tried    [SLOTS];
    logic [sdas_pkg::CNT_W-1:0] expected_next [$];
    int unsigned                mismatches;

    function new();
      max_symbols  = 65535;
      subpass_base = 1;
      repetitions  = 1;
      extra_mask   = '0;
      mismatches   = 0;
      foreach (position[s]) begin
        position[s] = '0;
        proposed[s] = '0;
        tried[s]    = '0;
      end
    endfunction

    function void set_register(logic [sdas_pkg::CFG_IDX_W-1:0] idx,
                               logic [sdas_pkg::CNT_W-1:0] value);
      case (idx)
        sdas_pkg::CFG_MAX_SYMBOLS:  max_symbols  = 32'(value);
        sdas_pkg::CFG_SUBPASS_BASE: subpass_base = 32'(value);
        sdas_pkg::CFG_REPETITIONS:  repetitions  = 32'(value[sdas_pkg::REP_W-1:0]);
        sdas_pkg::CFG_EXTRA_MASK:   extra_mask   = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned subpass_symbols(int unsigned sp);
      return subpass_base + (extra_mask[sp % 8] ? repetitions : 0);
    endfunction

    function bit all_subpasses_empty();
      for (int unsigned sp = 0; sp < 8; sp++)
        if (subpass_symbols(sp) != 0) return 1'b0;
      return 1'b1;
    endfunction

    // number of subpass additions the next request on this slot would take
    function int unsigned additions_needed(int unsigned slot, int unsigned try_count,
                                           int unsigned cap);
      int unsigned total, sp, n;
      if (try_count >= max_symbols || all_subpasses_empty()) return 0;
      total = 32'(proposed[slot]);
      sp    = 32'(position[slot]);
      n     = 0;
      while (total <= try_count && n <= cap) begin
        total += subpass_symbols(sp);
        sp     = (sp + 1) % 8;
        n++;
      end
      return n;
    endfunction

    // walk subpasses until past the last try, then clip to the maximum
    function logic [sdas_pkg::CNT_W-1:0] advance(int unsigned slot);
      int unsigned total, sp;
      if (32'(tried[slot]) >= max_symbols || all_subpasses_empty()) return '0;
      total = 32'(proposed[slot]);
      sp    = 32'(position[slot]);
      while (total <= 32'(tried[slot])) begin
        total += subpass_symbols(sp);
        sp     = (sp + 1) % 8;
      end
      if (total > max_symbols) total = max_symbols;
      proposed[slot] = total[sdas_pkg::CNT_W-1:0];
      position[slot] = sp[sdas_pkg::SP_W-1:0];
      return total[sdas_pkg::CNT_W-1:0];
    endfunction

    function void note_request(sdas_pkg::in_item_t req);
      int unsigned slot;
      slot = 32'(req.packet_index);
      case (req.op)
        sdas_pkg::OP_NEXT:   expected_next.push_back(advance(slot));
        sdas_pkg::OP_RECORD: tried[slot] = req.finished ? max_symbols[sdas_pkg::CNT_W-1:0]
                                                        : req.symbol_count;
        sdas_pkg::OP_CLEAR: begin
          position[slot] = '0;
          proposed[slot] = '0;
          tried[slot]    = '0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t  mismatch: %s", $time, what);
    endtask

    task check_count(sdas_pkg::out_item_t got);
      logic [sdas_pkg::CNT_W-1:0] want;
      if (expected_next.size() == 0) begin
        report_mismatch($sformatf("next_symbols %0d with no request waiting",
                                  got.next_symbols));
      end else begin
        want = expected_next.pop_front();
        if (got.next_symbols !== want)
          report_mismatch($sformatf("next_symbols got %0d want %0d",
                                    got.next_symbols, want));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sdas_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sdas_pkg::CNT_W-1:0]     cfg_wdata_i;

  sdas_stream_if #(.T(sdas_pkg::in_item_t))  req_if ();
  sdas_stream_if #(.T(sdas_pkg::out_item_t)) rsp_if ();

  attempt_model sched_model = new();

  bit          tail_quiet   = 1'b0;   // set for the last stretch of traffic
  int unsigned results_seen = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  strided_decode_attempt_scheduler #(
    .NUM_PACKETS (SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // --------------------------------------------------------------------------
  // request side; every task starts and ends on a falling edge
  // --------------------------------------------------------------------------
  function automatic sdas_pkg::in_item_t make_req(logic [1:0] op, int unsigned slot,
                                                  int unsigned count, bit fin);
    sdas_pkg::in_item_t req;
    req.op           = op;
    req.packet_index = slot[sdas_pkg::IDX_W-1:0];
    req.symbol_count = count[sdas_pkg::CNT_W-1:0];
    req.finished     = fin;
    return req;
  endfunction

  // present one beat and hold it until the block takes it
  task automatic send_req(sdas_pkg::in_item_t req);
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk_i); while (!req_if.ready);
    sched_model.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic hold_requests(int unsigned cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sdas_pkg::CFG_IDX_W-1:0] idx,
                           logic [sdas_pkg::CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sched_model.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // let every expected count come back, then give the last record time to land
  task automatic drain();
    hold_requests(1);
    while (sched_model.expected_next.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_settings(phase_t p);
    write_reg(sdas_pkg::CFG_MAX_SYMBOLS,  p.max_sym);
    write_reg(sdas_pkg::CFG_SUBPASS_BASE, p.base);
    write_reg(sdas_pkg::CFG_REPETITIONS,  sdas_pkg::CNT_W'(p.reps));
    write_reg(sdas_pkg::CFG_EXTRA_MASK,   sdas_pkg::CNT_W'(p.mask));
    // a slot whose next walk got too long under the new setting starts over
    for (int unsigned s = 0; s < SLOTS; s++)
      if (sched_model.additions_needed(s, 32'(sched_model.tried[s]), ADD_CAP) > ADD_CAP)
        send_req(make_req(sdas_pkg::OP_CLEAR, s, $urandom, $urandom_range(0, 1)));
  endtask

  // random request, mostly propose/record pairs on a few busy slots
  function automatic sdas_pkg::in_item_t random_req();
    sdas_pkg::in_item_t req;
    int unsigned        pick, slot, want, span;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 7) : $urandom_range(0, SLOTS - 1);
    req  = make_req(OP_UNUSED, slot, $urandom, $urandom_range(0, 1));
    if (pick < 45) begin
      req.op = sdas_pkg::OP_NEXT;
    end else if (pick < 88) begin
      req.op       = sdas_pkg::OP_RECORD;
      req.finished = ($urandom_range(0, 9) == 0);
      span = 0;
      for (int unsigned sp = 0; sp < 8; sp++) span += sched_model.subpass_symbols(sp);
      // a decoder mostly reports the count it was handed
      case ($urandom_range(0, 3))
        0, 1:    want = 32'(sched_model.proposed[slot]);
        2:       want = 32'(sched_model.proposed[slot]) + $urandom_range(0, 3 * span / 8 + 1);
        default: want = $urandom_range(0, 65535);
      endcase
      if (want > 65535) want = 65535;
      if (!req.finished && sched_model.additions_needed(slot, want, ADD_CAP) > ADD_CAP)
        want = 32'(sched_model.proposed[slot]);
      if (!req.finished) req.symbol_count = want[sdas_pkg::CNT_W-1:0];
    end else if (pick < 96) begin
      req.op = sdas_pkg::OP_CLEAR;
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold to back the block up
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    bit          rx_idle_on;
    bit          held;
    stall_left   = 0;
    rx_idle_on   = 1'b1;
    held         = 1'b0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        // requester keeps offering while results pile up
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!tail_quiet && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rx_idle_on = !rx_idle_on;
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        sched_model.check_count(rsp_if.data);
        results_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    phase_t             phases [NUM_PHASES];
    sdas_pkg::in_item_t opening [$];
    sdas_pkg::in_item_t wide_total [$];
    bit                 tx_idle_on;
    int unsigned        waited;

    // defaults, odd mask, smallest max, two all-empty settings, widest sums,
    // two live subpasses only, then a random one
    phases[0] = '{16'd65535, 16'd1,     8'd1,   8'h00, 400};
    phases[1] = '{16'd1000,  16'd3,     8'd5,   8'hA5, 300};
    phases[2] = '{16'd1,     16'd0,     8'd255, 8'h01, 200};
    phases[3] = '{16'd20000, 16'd0,     8'd0,   8'hFF, 60};
    phases[4] = '{16'd500,   16'd0,     8'd255, 8'h00, 60};
    phases[5] = '{16'd65535, 16'd65535, 8'd255, 8'hFF, 290};
    phases[6] = '{16'd40000, 16'd0,     8'd200, 8'h12, 250};
    phases[7] = '{16'($urandom_range(1, 65535)), 16'($urandom_range(0, 40)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 390};

    // fresh slots under the defaults: first proposal, record then propose,
    // repeat proposal, max reached, finished attempt, slot reset, unused op
    opening = '{
      make_req(sdas_pkg::OP_NEXT,   0,  0,      0),
      make_req(sdas_pkg::OP_RECORD, 0,  10,     0),
      make_req(sdas_pkg::OP_NEXT,   0,  0,      0),
      make_req(sdas_pkg::OP_NEXT,   0,  0,      0),
      make_req(sdas_pkg::OP_RECORD, 63, 65535,  0),
      make_req(sdas_pkg::OP_NEXT,   63, 0,      0),
      make_req(sdas_pkg::OP_RECORD, 1,  0,      1),
      make_req(sdas_pkg::OP_NEXT,   1,  0,      0),
      make_req(sdas_pkg::OP_CLEAR,  63, 65535,  1),
      make_req(sdas_pkg::OP_NEXT,   63, 0,      0),
      make_req(OP_UNUSED,           5,  'hAAAA, 1),
      make_req(sdas_pkg::OP_NEXT,   5,  0,      0),
      make_req(sdas_pkg::OP_RECORD, 2,  200,    0),
      make_req(sdas_pkg::OP_NEXT,   2,  0,      0)
    };
    // running total above 16 bits before the clip
    wide_total = '{
      make_req(sdas_pkg::OP_RECORD, 3, 65534,  0),
      make_req(sdas_pkg::OP_NEXT,   3, 0,      0),
      make_req(sdas_pkg::OP_NEXT,   3, 0,      0),
      make_req(sdas_pkg::OP_RECORD, 4, 'h5555, 0),
      make_req(sdas_pkg::OP_NEXT,   4, 0,      0)
    };

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    tx_idle_on   = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the block sweeps its store after reset with ready low
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (!req_if.ready && waited < 4 * SLOTS);
    @(negedge clk_i);

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      load_settings(phases[ph]);
      if (ph == 0) foreach (opening[k]) send_req(opening[k]);
      if (ph == 5) foreach (wide_total[k]) send_req(wide_total[k]);
      for (int unsigned n = 0; n < phases[ph].items; n++) begin
        if (n % 64 == 0) tx_idle_on = ($urandom_range(0, 9) < 7);
        if (ph == NUM_PHASES - 1 && phases[ph].items - n <= TAIL_ITEMS) tail_quiet = 1'b1;
        if (!tail_quiet && tx_idle_on && $urandom_range(0, 4) == 0)
          hold_requests($urandom_range(1, 18));
        send_req(random_req());
      end
      drain();
    end

    if (sched_model.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hung handshake or lost result
  initial begin
    #(LIMIT_TIME);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
